@@ src/tod_pkg.sv @@
// tod_pkg: shared widths, fixed-point constants, register indexes and types
// for the tilt orientation detector. No dependencies.
package tod_pkg;

   localparam int FRAC_BITS    = 8;
   localparam int SAMPLE_W     = 16;
   localparam int FILT_W       = SAMPLE_W + FRAC_BITS;
   localparam int WEIGHT_NUM   = 13107;
   localparam int WEIGHT_SHIFT = 16;
   localparam int WEIGHT_W     = 15;
   localparam int PROD_W       = FILT_W + 1 + WEIGHT_W;
   localparam int THRESH_W     = 15;
   localparam int ROT_W        = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 15;

   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(2458);

   localparam logic [ROT_W-1:0] ROT_Q0 = ROT_W'(0);
   localparam logic [ROT_W-1:0] ROT_Q1 = ROT_W'(1);
   localparam logic [ROT_W-1:0] ROT_Q2 = ROT_W'(2);
   localparam logic [ROT_W-1:0] ROT_Q3 = ROT_W'(3);

   localparam logic [CSR_INDEX_W-1:0] CSR_TILT_THRESHOLD       = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROTATION_LOCK_ENABLE = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCKED_ROTATION      = CSR_INDEX_W'(2);

   typedef struct packed {
      logic [THRESH_W-1:0] threshold;
      logic                lock_en;
      logic [ROT_W-1:0]    locked_rot;
   } cfg_type;

endpackage

@@ src/tilt_orientation_detector_core.sv @@
// Tilt orientation detector core: three smoothing lanes feed one rotation
// merge stage. Depends on tod_pkg, tod_axis_lane and tod_rotation_merge.
//
// Usage:
//   req_* carries one raw accelerometer sample per item (signed 16-bit counts).
//   rsp_* returns one result per item: rotation quadrant, a changed flag and
//   the integer part of the three smoothed axes.
//   csr_* writes tilt_threshold (0), rotation_lock_enable (1) and
//   locked_rotation (2); other indexes are ignored. Write only while idle.
// Timing:
//   An accepted item updates the lane filters at the accepting edge; the merge
//   stage registers the result once the output register is free or its result
//   is taken, raising rsp_valid. One item per cycle is sustained while rsp_stall
//   is low; the filter update (subtract, 25x15 multiply, add) in each lane sets the cycle.
// Reset (synchronous): filters and rotation clear to zero, registers return
//   to threshold 2458, lock off, locked quadrant 0; both stages empty.
// Stall: a stalled result holds in the output register while one more item
//   may enter the lane stage; with both stages full and stalled, req_stall is raised.
module tilt_orientation_detector_core
   import tod_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic signed [SAMPLE_W-1:0] req_accel_z,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ROT_W-1:0]           rsp_rotation,
   output logic                       rsp_rotation_changed,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_x,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_y,
   output logic signed [SAMPLE_W-1:0] rsp_smooth_z,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   cfg_type cfg_ff;
   logic    lane_full_ff, lane_full_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    in_accept, out_load;

   logic signed [FILT_W-1:0]   filt_x, filt_y, filt_z;
   logic signed [SAMPLE_W-1:0] sm_x, sm_y, sm_z;

   always_comb begin
      out_load     = lane_full_ff && (!rsp_valid_ff || !rsp_stall);
      req_stall    = lane_full_ff && !out_load;
      in_accept    = req_valid && !req_stall;
      lane_full_in = in_accept || (lane_full_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lane_full_ff <= lane_full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= THRESH_RESET;
         cfg_ff.lock_en    <= 1'b0;
         cfg_ff.locked_rot <= ROT_Q0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TILT_THRESHOLD: begin
               cfg_ff.threshold <= csr_write_data[THRESH_W-1:0];
            end
            CSR_ROTATION_LOCK_ENABLE: begin
               cfg_ff.lock_en <= csr_write_data[0];
            end
            CSR_LOCKED_ROTATION: begin
               cfg_ff.locked_rot <= csr_write_data[ROT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tod_axis_lane u_lane_x (
      .clock        (clock),
      .reset        (reset),
      .load         (in_accept),
      .sample       (req_accel_x),
      .filter_state (filt_x),
      .smooth_int   (sm_x)
   );

   tod_axis_lane u_lane_y (
      .clock        (clock),
      .reset        (reset),
      .load         (in_accept),
      .sample       (req_accel_y),
      .filter_state (filt_y),
      .smooth_int   (sm_y)
   );

   // z is smoothed but takes no part in the rotation decision
   tod_axis_lane u_lane_z (
      .clock        (clock),
      .reset        (reset),
      .load         (in_accept),
      .sample       (req_accel_z),
      .filter_state (filt_z),
      .smooth_int   (sm_z)
   );

   tod_rotation_merge u_merge (
      .clock            (clock),
      .reset            (reset),
      .load             (out_load),
      .cfg              (cfg_ff),
      .filt_x           (filt_x),
      .filt_y           (filt_y),
      .smooth_x         (sm_x),
      .smooth_y         (sm_y),
      .smooth_z         (sm_z),
      .rotation         (rsp_rotation),
      .rotation_changed (rsp_rotation_changed),
      .smooth_x_out     (rsp_smooth_x),
      .smooth_y_out     (rsp_smooth_y),
      .smooth_z_out     (rsp_smooth_z)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ src/tod_axis_lane.sv @@
// tod_axis_lane: one axis of exponential smoothing, new = old + 0.2*(sample - old)
// in signed 16.FRAC_BITS fixed point. Depends on tod_pkg.
module tod_axis_lane
   import tod_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [FILT_W-1:0]   filter_state,
   output logic signed [SAMPLE_W-1:0] smooth_int
);

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_S = WEIGHT_W'(WEIGHT_NUM);

   logic signed [FILT_W-1:0] filter_ff, filter_in;
   logic signed [FILT_W-1:0] sample_scaled;
   logic signed [FILT_W:0]   diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] step;
   logic signed [FILT_W:0]   sum;

   always_comb begin
      sample_scaled = {sample, FRAC_BITS'(0)};
      diff = {sample_scaled[FILT_W-1], sample_scaled} - {filter_ff[FILT_W-1], filter_ff};
      prod = PROD_W'(diff) * PROD_W'(WEIGHT_S);
      // arithmetic shift gives the floor of the weighted step
      step = prod >>> WEIGHT_SHIFT;
      // update lies between old state and scaled sample, so it stays in range
      sum = {filter_ff[FILT_W-1], filter_ff} + step[FILT_W:0];
      filter_in = sum[FILT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= '0;
      end else if (load) begin
         filter_ff <= filter_in;
      end
   end

   assign filter_state = filter_ff;
   assign smooth_int   = filter_ff[FILT_W-1:FRAC_BITS];

endmodule

@@ src/tod_rotation_merge.sv @@
// tod_rotation_merge: sets the rotation quadrant from the smoothed X and Y
// lanes or the lock setting, holds the result register. Depends on tod_pkg.
module tod_rotation_merge
   import tod_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  cfg_type                    cfg,
   input  logic signed [FILT_W-1:0]   filt_x,
   input  logic signed [FILT_W-1:0]   filt_y,
   input  logic signed [SAMPLE_W-1:0] smooth_x,
   input  logic signed [SAMPLE_W-1:0] smooth_y,
   input  logic signed [SAMPLE_W-1:0] smooth_z,
   output logic [ROT_W-1:0]           rotation,
   output logic                       rotation_changed,
   output logic signed [SAMPLE_W-1:0] smooth_x_out,
   output logic signed [SAMPLE_W-1:0] smooth_y_out,
   output logic signed [SAMPLE_W-1:0] smooth_z_out
);

   logic [ROT_W-1:0]           rot_ff, rot_in;
   logic                       changed_ff;
   logic signed [SAMPLE_W-1:0] sx_ff, sy_ff, sz_ff;
   logic signed [FILT_W:0]     t_pos, t_neg, fx, fy;

   always_comb begin
      t_pos = $signed((FILT_W+1)'({cfg.threshold, FRAC_BITS'(0)}));
      t_neg = -t_pos;
      fx = (FILT_W+1)'(filt_x);
      fy = (FILT_W+1)'(filt_y);
      rot_in = rot_ff;
      if (cfg.lock_en) begin
         rot_in = cfg.locked_rot;
      end else if (fy < t_neg) begin
         rot_in = ROT_Q0;
      end else if (fx > t_pos) begin
         rot_in = ROT_Q1;
      end else if (fy > t_pos) begin
         rot_in = ROT_Q2;
      end else if (fx < t_neg) begin
         rot_in = ROT_Q3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff     <= ROT_Q0;
         changed_ff <= 1'b0;
      end else if (load) begin
         rot_ff     <= rot_in;
         changed_ff <= (rot_in != rot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sx_ff <= smooth_x;
         sy_ff <= smooth_y;
         sz_ff <= smooth_z;
      end
   end

   assign rotation         = rot_ff;
   assign rotation_changed = changed_ff;
   assign smooth_x_out     = sx_ff;
   assign smooth_y_out     = sy_ff;
   assign smooth_z_out     = sz_ff;

   a_lock_forces: assert property (@(posedge clock) disable iff (reset)
      load && cfg.lock_en |=> rot_ff == $past(cfg.locked_rot))
      else $error("locked rotation not applied");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      load |=> changed_ff == (rot_ff != $past(rot_ff)))
      else $error("rotation_changed does not match rotation update");

   a_y_low_wins: assert property (@(posedge clock) disable iff (reset)
      load && !cfg.lock_en && (fy < t_neg) |=> rot_ff == ROT_Q0)
      else $error("y below threshold did not select quadrant 0");

endmodule
